@@ rtl/u8dec_pkg.sv @@
`default_nettype none

package u8dec_pkg;

  // Longest sequence in the original UTF-8 form, and its continuation count
  localparam int unsigned MaxSeq  = 6;
  localparam int unsigned NumCont = MaxSeq - 1;

  // Input transaction: one lead byte, five candidate continuation bytes
  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] cont_byte_1;
    logic [7:0] cont_byte_2;
    logic [7:0] cont_byte_3;
    logic [7:0] cont_byte_4;
    logic [7:0] cont_byte_5;
    logic [2:0] bytes_available;
  } u8dec_in_t;

  // Result transaction
  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  seq_length;
  } u8dec_out_t;

  // Lead stage -> check stage
  typedef struct packed {
    logic [2:0]               len;
    logic [6:0]               payload;
    logic [NumCont-1:0][7:0]  cont;
    logic [2:0]               avail;
  } u8dec_lead_t;

  // Check stage -> pack stage
  typedef struct packed {
    logic [2:0]               len;
    logic [6:0]               payload;
    logic [NumCont-1:0][5:0]  bits;
  } u8dec_chk_t;

endpackage

`default_nettype wire

@@ rtl/utf8_sequence_decoder_top.sv @@
`default_nettype none

// UTF-8 sequence decoder, original 1 to 6 byte form. Each transaction gives
// a lead byte, five following bytes and the count of valid bytes (7 counts
// as 6). busy stays low, so a transaction is taken in every cycle that
// start is high. Each result appears on result_o with done_o high for one
// cycle, one result per transaction and in order, after passing the three
// register stages (lead decode, length/continuation check, bit packing). The
// receiver cannot stall and must take each result in its strobe cycle.
// seq_length 0 flags a bad lead (code_point 0), or a truncated sequence or
// bad continuation byte (code_point holds the lead payload bits).
// Overlong forms and surrogates pass unchecked.
module utf8_sequence_decoder_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire u8dec_pkg::u8dec_in_t  in_i,
  output logic                       done_o,
  output u8dec_pkg::u8dec_out_t      result_o
);
  import u8dec_pkg::*;

  logic        lead_valid, chk_valid;
  u8dec_lead_t lead;
  u8dec_chk_t  chk;

  // Fully pipelined, never stalls
  assign busy = 1'b0;

  u8dec_lead u_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .in_i    (in_i),
    .valid_o (lead_valid),
    .lead_o  (lead)
  );

  u8dec_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lead_valid),
    .lead_i  (lead),
    .valid_o (chk_valid),
    .chk_o   (chk)
  );

  u8dec_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chk_valid),
    .chk_i   (chk),
    .valid_o (done_o),
    .res_o   (result_o)
  );

endmodule

`default_nettype wire

@@ rtl/u8dec_lead.sv @@
`default_nettype none

module u8dec_lead (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire u8dec_pkg::u8dec_in_t   in_i,
  output logic                        valid_o,
  output u8dec_pkg::u8dec_lead_t      lead_o
);
  import u8dec_pkg::*;

  u8dec_lead_t lead_d, lead_q;
  logic        valid_q;
  logic [7:0]  lb;

  assign lb = in_i.lead_byte;

  // Lead byte sets length and payload mask; saturate the byte count
  always_comb begin
    lead_d.cont[0] = in_i.cont_byte_1;
    lead_d.cont[1] = in_i.cont_byte_2;
    lead_d.cont[2] = in_i.cont_byte_3;
    lead_d.cont[3] = in_i.cont_byte_4;
    lead_d.cont[4] = in_i.cont_byte_5;
    lead_d.avail   = (in_i.bytes_available == 3'd7) ? 3'd6 : in_i.bytes_available;
    if ((lb & 8'h80) == 8'h00) begin
      lead_d.len = 3'd1; lead_d.payload = lb[6:0];
    end else if ((lb & 8'he0) == 8'hc0) begin
      lead_d.len = 3'd2; lead_d.payload = {2'b00, lb[4:0]};
    end else if ((lb & 8'hf0) == 8'he0) begin
      lead_d.len = 3'd3; lead_d.payload = {3'b000, lb[3:0]};
    end else if ((lb & 8'hf8) == 8'hf0) begin
      lead_d.len = 3'd4; lead_d.payload = {4'b0000, lb[2:0]};
    end else if ((lb & 8'hfc) == 8'hf8) begin
      lead_d.len = 3'd5; lead_d.payload = {5'b00000, lb[1:0]};
    end else if ((lb & 8'hfe) == 8'hfc) begin
      lead_d.len = 3'd6; lead_d.payload = {6'b000000, lb[0]};
    end else begin
      // bad lead: continuation byte or 0xfe/0xff
      lead_d.len = 3'd0; lead_d.payload = 7'd0;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lead_q <= lead_d;
    end
  end

  assign valid_o = valid_q;
  assign lead_o  = lead_q;

endmodule

`default_nettype wire

@@ rtl/u8dec_check.sv @@
`default_nettype none

module u8dec_check (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire u8dec_pkg::u8dec_lead_t  lead_i,
  output logic                         valid_o,
  output u8dec_pkg::u8dec_chk_t        chk_o
);
  import u8dec_pkg::*;

  u8dec_chk_t         chk_d, chk_q;
  logic               valid_q;
  logic [NumCont-1:0] cont_bad;
  logic               fail;

  // A continuation byte inside the sequence must carry the 10 prefix
  always_comb begin
    for (int k = 0; k < NumCont; k++) begin
      cont_bad[k] = (lead_i.cont[k][7:6] != 2'b10) && (3'(k + 1) < lead_i.len);
      chk_d.bits[k] = lead_i.cont[k][5:0];
    end
    fail          = (lead_i.len > lead_i.avail) || (|cont_bad);
    chk_d.len     = fail ? 3'd0 : lead_i.len;
    chk_d.payload = lead_i.payload;
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      chk_q <= chk_d;
    end
  end

  assign valid_o = valid_q;
  assign chk_o   = chk_q;

endmodule

`default_nettype wire

@@ rtl/u8dec_pack.sv @@
`default_nettype none

module u8dec_pack (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire u8dec_pkg::u8dec_chk_t  chk_i,
  output logic                        valid_o,
  output u8dec_pkg::u8dec_out_t       res_o
);
  import u8dec_pkg::*;

  u8dec_out_t res_d, res_q;
  logic       valid_q;

  // Append six bits per continuation byte, most significant first
  always_comb begin
    res_d.seq_length = chk_i.len;
    case (chk_i.len)
      3'd2: res_d.code_point = 31'({chk_i.payload, chk_i.bits[0]});
      3'd3: res_d.code_point = 31'({chk_i.payload, chk_i.bits[0], chk_i.bits[1]});
      3'd4: res_d.code_point = 31'({chk_i.payload, chk_i.bits[0], chk_i.bits[1],
                                    chk_i.bits[2]});
      3'd5: res_d.code_point = 31'({chk_i.payload, chk_i.bits[0], chk_i.bits[1],
                                    chk_i.bits[2], chk_i.bits[3]});
      3'd6: res_d.code_point = {chk_i.payload[0], chk_i.bits[0], chk_i.bits[1],
                                chk_i.bits[2], chk_i.bits[3], chk_i.bits[4]};
      // one byte, or failure: lead payload alone
      default: res_d.code_point = 31'(chk_i.payload);
    endcase
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
